// ----- hdl/binary_edge_template_classifier_unit_defines.svh -----
// Assertion macros shared by the binary edge template classifier RTL.
`ifndef BINARY_EDGE_TEMPLATE_CLASSIFIER_UNIT_DEFINES_SVH
`define BINARY_EDGE_TEMPLATE_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BETC_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BETC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hdl/betc_pkg.sv -----
// Shared constants for the binary edge template classifier.
package betc_pkg;

    // Default sizes of the template store.
    localparam int PIXEL_COUNT_DEFAULT    = 10000;
    localparam int TEMPLATE_SLOTS_DEFAULT = 8;

    // Field widths of the item, result and configuration transfers.
    localparam int SLOT_FIELD_W  = 3;
    localparam int PIXEL_FIELD_W = 14;
    localparam int EDGE_W        = 8;
    localparam int CLASS_W       = 3;
    localparam int COUNT_W       = 14;
    localparam int PCT_W         = 7;
    localparam int TCOUNT_W      = 4;
    localparam int CLASSES_W     = 24;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 24;

    // Item action codes.
    localparam logic ACTION_LOAD     = 1'b0;
    localparam logic ACTION_CLASSIFY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_TEMPLATE_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMPLATE_CLASSES = 2'd1;

    // Counters saturate here; the percentage is clamped to this value.
    localparam logic [COUNT_W-1:0] COUNTER_MAX = 14'd16383;
    localparam int PERCENT_MAX = 100;

    // Percentage by reciprocal multiply: dividend is count * 100, below 2^21.
    localparam int DIVIDEND_W = 21;
    localparam int RECIP_W    = 30;

endpackage

// ----- hdl/betc_item_if.sv -----
// Input item channel: template loads and image pixels.
interface betc_item_if;
    import betc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [SLOT_FIELD_W-1:0]  template_slot;
    logic [PIXEL_FIELD_W-1:0] pixel_index;
    logic [EDGE_W-1:0]        edge_value;
    logic                     last;

    modport source (output valid, action, template_slot, pixel_index, edge_value, last,
                    input ready);
    modport sink   (input valid, action, template_slot, pixel_index, edge_value, last,
                    output ready);
endinterface

// ----- hdl/betc_result_if.sv -----
// Result channel: class, count and percentage of the best template.
interface betc_result_if;
    import betc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] coin_class;
    logic [COUNT_W-1:0] best_count;
    logic [PCT_W-1:0]   match_percent;

    modport source (output valid, coin_class, best_count, match_percent, input ready);
    modport sink   (input valid, coin_class, best_count, match_percent, output ready);
endinterface

// ----- hdl/betc_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface betc_cfg_if;
    import betc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/binary_edge_template_classifier_unit.sv -----
// Binary edge template classifier: template store, per-slot match counters, argmax.
// Throughput: one item per cycle; a load or pixel transfer is taken every clock unless input stalls.
// A last pixel's result passes through the counter update and snapshot, the best-slot
// search, the reciprocal multiply and the output register; the store is read at the
// accepting edge. Only a last pixel waiting on a full result path stalls input.
// Reset clears counters, configuration and valid flags; the template store is not cleared.
`include "binary_edge_template_classifier_unit_defines.svh"

module binary_edge_template_classifier_unit #(
    parameter int PIXEL_COUNT    = betc_pkg::PIXEL_COUNT_DEFAULT,
    parameter int TEMPLATE_SLOTS = betc_pkg::TEMPLATE_SLOTS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    betc_item_if.sink     item,
    betc_result_if.source result,
    betc_cfg_if.sink      cfg
);
    import betc_pkg::*;

    localparam int ADDR_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int SLOT_W  = (TEMPLATE_SLOTS > 1) ? $clog2(TEMPLATE_SLOTS) : 1;
    // floor(x / PIXEL_COUNT) == (x * RECIP) >> SHIFT for every x below 2^DIVIDEND_W.
    localparam int SHIFT   = DIVIDEND_W + $clog2(PIXEL_COUNT);
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(PIXEL_COUNT) - 64'd1) / 64'(PIXEL_COUNT);
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(RECIP * 64'd100);
    localparam int PROD_W  = COUNT_W + RECIP_W;

    // Configuration registers.
    logic [TCOUNT_W-1:0]  tcount_reg;
    logic [CLASSES_W-1:0] classes_reg;
    logic [TEMPLATE_SLOTS-1:0] slot_mask;

    // Template store: bit s of an entry is the edge bit of slot s.
    logic [TEMPLATE_SLOTS-1:0] tmpl_mem [PIXEL_COUNT];
    logic                      item_accept;
    logic                      item_in_range;
    logic [ADDR_W-1:0]         item_addr;
    logic                      tmpl_wr_en;

    // Counting stage.
    logic                      s1_valid_reg;
    logic                      s1_count_reg;
    logic                      s1_last_reg;
    logic [TEMPLATE_SLOTS-1:0] bits_reg;
    logic                      s1_go;
    logic                      s1_free;
    logic [TEMPLATE_SLOTS-1:0][COUNT_W-1:0] cnt_reg;
    logic [TEMPLATE_SLOTS-1:0][COUNT_W-1:0] cnt_next;

    // Result stages.
    logic                      snap_valid_reg;
    logic [TEMPLATE_SLOTS-1:0][COUNT_W-1:0] snap_reg;
    logic                      snap_free;
    logic                      best_valid_reg;
    logic [COUNT_W-1:0]        best_count_reg;
    logic [CLASS_W-1:0]        best_class_reg;
    logic [COUNT_W-1:0]        best_count_next;
    logic [CLASS_W-1:0]        best_class_next;
    logic                      best_free;
    logic                      prod_valid_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [COUNT_W-1:0]        prod_count_reg;
    logic [CLASS_W-1:0]        prod_class_reg;
    logic                      prod_free;
    logic [PROD_W-1:0]         quotient;
    logic [PCT_W-1:0]          pct_next;
    logic                      out_valid_reg;
    logic [CLASS_W-1:0]        out_class_reg;
    logic [COUNT_W-1:0]        out_count_reg;
    logic [PCT_W-1:0]          out_pct_reg;
    logic                      out_free;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcount_reg  <= '0;
            classes_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TEMPLATE_COUNT:   tcount_reg  <= cfg.data[TCOUNT_W-1:0];
                REG_TEMPLATE_CLASSES: classes_reg <= cfg.data[CLASSES_W-1:0];
                default:              ;
            endcase
        end
    end

    // Slots below the programmed count take part; larger counts act as all slots.
    always_comb
    begin
        for (int s = 0; s < TEMPLATE_SLOTS; s++)
        begin
            slot_mask[s] = 32'(tcount_reg) > s;
        end
    end

    // Backpressure chain from the output register down to the item channel.
    assign out_free   = !out_valid_reg || result.ready;
    assign prod_free  = !prod_valid_reg || out_free;
    assign best_free  = !best_valid_reg || prod_free;
    assign snap_free  = !snap_valid_reg || best_free;
    assign s1_go      = s1_valid_reg && (!s1_last_reg || snap_free);
    assign s1_free    = !s1_valid_reg || s1_go;
    assign item.ready = s1_free;

    assign item_accept   = item.valid && item.ready;
    assign item_in_range = 32'(item.pixel_index) < PIXEL_COUNT;
    assign item_addr     = ADDR_W'(item.pixel_index);
    assign tmpl_wr_en    = item_accept && (item.action == ACTION_LOAD) && item_in_range
                           && (32'(item.template_slot) < TEMPLATE_SLOTS);

    // Store write of one template bit and registered read on every accepted transfer.
    always_ff @(posedge clk)
    begin
        if (tmpl_wr_en)
        begin
            tmpl_mem[item_addr][SLOT_W'(item.template_slot)] <= (item.edge_value != '0);
        end
        if (item_accept)
        begin
            bits_reg <= tmpl_mem[item_addr];
        end
    end

    // Counting stage control: only pixel transfers enter it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= item_accept && (item.action == ACTION_CLASSIFY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_count_reg <= (item.edge_value != '0) && item_in_range;
            s1_last_reg  <= item.last;
        end
    end

    // Saturating per-slot counter increments.
    always_comb
    begin
        for (int s = 0; s < TEMPLATE_SLOTS; s++)
        begin
            if (s1_count_reg && bits_reg[s] && slot_mask[s] && (cnt_reg[s] != COUNTER_MAX))
            begin
                cnt_next[s] = cnt_reg[s] + COUNT_W'(1);
            end
            else
            begin
                cnt_next[s] = cnt_reg[s];
            end
        end
    end

    // Counters clear once the last pixel of an image has been counted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (s1_go)
        begin
            if (s1_last_reg)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // Snapshot of the final counts of an image.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (snap_free)
        begin
            snap_valid_reg <= s1_go && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            snap_reg <= cnt_next;
        end
    end

    // Best slot search: strictly greater wins, so the lowest slot wins a tie.
    always_comb
    begin
        best_count_next = '0;
        best_class_next = '0;
        for (int s = 0; s < TEMPLATE_SLOTS; s++)
        begin
            if (slot_mask[s] && (snap_reg[s] > best_count_next))
            begin
                best_count_next = snap_reg[s];
                best_class_next = classes_reg[CLASS_W*s +: CLASS_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
        end
        else if (best_free)
        begin
            best_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (best_free && snap_valid_reg)
        begin
            best_count_reg <= best_count_next;
            best_class_reg <= best_class_next;
        end
    end

    // Reciprocal multiply for count * 100 / PIXEL_COUNT.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (prod_free)
        begin
            prod_valid_reg <= best_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_free && best_valid_reg)
        begin
            prod_reg       <= PROD_W'(best_count_reg) * PROD_W'(RECIP_100);
            prod_count_reg <= best_count_reg;
            prod_class_reg <= best_class_reg;
        end
    end

    // Quotient and clamp to a full match.
    assign quotient = prod_reg >> SHIFT;
    assign pct_next = (quotient > PROD_W'(PERCENT_MAX)) ? PCT_W'(PERCENT_MAX)
                                                        : quotient[PCT_W-1:0];

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && prod_valid_reg)
        begin
            out_class_reg <= prod_class_reg;
            out_count_reg <= prod_count_reg;
            out_pct_reg   <= pct_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.coin_class    = out_class_reg;
    assign result.best_count    = out_count_reg;
    assign result.match_percent = out_pct_reg;

    // A counted last pixel leaves a snapshot behind and cleared counters.
    `BETC_ASSERT_NEXT(a_last_clears, s1_go && s1_last_reg,
        snap_valid_reg && (cnt_reg == '0), "counters not cleared after last pixel")

    // A stalled counting stage keeps its store read data.
    `BETC_ASSERT_NEXT(a_stall_holds_read, s1_valid_reg && !s1_go,
        bits_reg === $past(bits_reg), "store read data changed during stall")

    // A result with no matching pixels is class zero at zero percent.
    `BETC_ASSERT_NOW(a_no_match, out_valid_reg && (out_count_reg == '0),
        (out_class_reg == '0) && (out_pct_reg == '0), "nonzero class or percent without a match")

endmodule
